// ----- sv/kemt_pkg.sv -----
// ----------------------------------------------------------------------------
// Keyword exact-match table package
// Sizes, field widths and opcodes shared by the keyword table RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package kemt_pkg;

    // Table dimensions
    localparam int NUM_KEYWORDS    = 16;
    localparam int MAX_KEYWORD_LEN = 16;

    // Fixed field widths of the transfer payloads
    localparam int OPCODE_W = 2;
    localparam int ENTRY_W  = 4;
    localparam int POSIN_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int TAG_W    = 16;

    // Derived widths
    localparam int IDX_W  = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
    localparam int ADDR_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
    // word position counts up to MAX_KEYWORD_LEN + 1
    localparam int WPOS_W = $clog2(MAX_KEYWORD_LEN + 2);

    localparam logic [WPOS_W-1:0] WPOS_MAX = WPOS_W'(MAX_KEYWORD_LEN);
    localparam logic [WPOS_W-1:0] WPOS_SAT = WPOS_W'(MAX_KEYWORD_LEN + 1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_KEY_BYTE = 2'd0,
        OP_HEADER   = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_END      = 2'd3
    } t_opcode;

endpackage

`default_nettype wire

// ----- sv/kemt_ifs.sv -----
// ----------------------------------------------------------------------------
// Keyword exact-match table channels
// Valid/ready channels for load and lookup items and for match results.
// ----------------------------------------------------------------------------
`default_nettype none

interface kemt_in_if;
    logic                         valid;
    logic                         ready;
    logic [kemt_pkg::OPCODE_W-1:0] opcode;
    logic [kemt_pkg::ENTRY_W-1:0]  entry;
    logic [kemt_pkg::POSIN_W-1:0]  position;
    logic [kemt_pkg::BYTE_W-1:0]   byte_value;
    logic [kemt_pkg::LEN_W-1:0]    keyword_len;
    logic [kemt_pkg::TAG_W-1:0]    tag;
    logic                         enable;

    modport source (output valid, opcode, entry, position, byte_value,
                    keyword_len, tag, enable, input ready);
    modport sink   (input valid, opcode, entry, position, byte_value,
                    keyword_len, tag, enable, output ready);
endinterface

interface kemt_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [kemt_pkg::TAG_W-1:0]    match_tag;
    logic [kemt_pkg::ENTRY_W-1:0]  match_entry;

    modport source (output valid, found, match_tag, match_entry, input ready);
    modport sink   (input valid, found, match_tag, match_entry, output ready);
endinterface

`default_nettype wire

// ----- sv/kemt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module kemt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // storage write and registered read; data holds when not read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/keyword_exact_match_table.sv -----
// ----------------------------------------------------------------------------
// Keyword exact-match table
// Keyword dictionary: load items fill keyword bytes and entry headers, lookup
// items stream a word byte by byte, and an end item reports the lowest entry
// whose active keyword equals the word exactly.
//
//   channel  dir  items                                 result
//   i_in     in   key byte / header / lookup byte / end  -
//   o_out    out  -                                     found, tag, entry
//
// One item per cycle is accepted unless the match stage stalls. An item goes
// through the input stage (keyword RAM read at the current word position)
// then the match stage; an end item's result sits in the output register.
// Synchronous active-low reset clears headers' active bits, lengths and the
// word position, sets all match bits; keyword bytes and tags are not reset.
// A result waiting in the output register stalls input only when the next
// end item reaches the match stage.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_exact_match_table (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    kemt_in_if.sink        i_in,
    kemt_out_if.source     o_out
);

    localparam int NK = kemt_pkg::NUM_KEYWORDS;

    // front end: accept and word position at accept time
    logic                           in_fire;
    logic [kemt_pkg::WPOS_W-1:0]    r_pos;
    logic [kemt_pkg::BYTE_W-1:0]    ram_q [NK];

    // match stage registers
    logic                           r_s1_valid;
    kemt_pkg::t_opcode              r_s1_op;
    logic [kemt_pkg::WPOS_W-1:0]    r_s1_pos;
    logic [kemt_pkg::BYTE_W-1:0]    r_s1_byte;
    logic [kemt_pkg::IDX_W-1:0]     r_s1_idx;
    logic                           r_s1_inrange;
    logic [kemt_pkg::LEN_W-1:0]     r_s1_len;
    logic [kemt_pkg::TAG_W-1:0]     r_s1_tag;
    logic                           r_s1_en;
    logic                           s1_go;

    // table headers and lookup state
    logic [kemt_pkg::LEN_W-1:0]     r_len [NK];
    logic [kemt_pkg::TAG_W-1:0]     r_tag [NK];
    logic [NK-1:0]                  r_act;
    logic [NK-1:0]                  r_match;
    logic [NK-1:0]                  n_match;

    // end-of-word search
    logic [NK-1:0]                  hit;
    logic                           any_hit;
    logic [kemt_pkg::IDX_W-1:0]     hit_idx;

    // output register
    logic                           r_out_valid;
    logic                           r_out_found;
    logic [kemt_pkg::TAG_W-1:0]     r_out_tag;
    logic [kemt_pkg::ENTRY_W-1:0]   r_out_entry;

    assign s1_go = r_s1_valid &&
                   (r_s1_op != kemt_pkg::OP_END || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in.valid && i_in.ready;

    // word position: counts lookup bytes, saturates, cleared by end of word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (in_fire) begin
            if (i_in.opcode == kemt_pkg::OP_LOOKUP) begin
                if (r_pos != kemt_pkg::WPOS_SAT) begin
                    r_pos <= r_pos + 1'b1;
                end
            end else if (i_in.opcode == kemt_pkg::OP_END) begin
                r_pos <= '0;
            end
        end
    end

    // one keyword RAM per entry, addressed by byte position
    for (genvar g = 0; g < NK; g++) begin : g_kw
        logic kw_we;
        assign kw_we = in_fire && i_in.opcode == kemt_pkg::OP_KEY_BYTE &&
                       int'(i_in.entry) == g &&
                       int'(i_in.position) < kemt_pkg::MAX_KEYWORD_LEN;
        kemt_ram #(
            .WIDTH (kemt_pkg::BYTE_W),
            .DEPTH (kemt_pkg::MAX_KEYWORD_LEN)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (kw_we),
            .i_waddr (kemt_pkg::ADDR_W'(i_in.position)),
            .i_wdata (i_in.byte_value),
            .i_re    (in_fire && i_in.opcode == kemt_pkg::OP_LOOKUP),
            .i_raddr (kemt_pkg::ADDR_W'(r_pos)),
            .o_rdata (ram_q[g])
        );
    end

    // input stage -> match stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op      <= kemt_pkg::t_opcode'(i_in.opcode);
            r_s1_pos     <= r_pos;
            r_s1_byte    <= i_in.byte_value;
            r_s1_idx     <= kemt_pkg::IDX_W'(i_in.entry);
            r_s1_inrange <= int'(i_in.entry) < NK;
            r_s1_len     <= i_in.keyword_len;
            r_s1_tag     <= i_in.tag;
            r_s1_en      <= i_in.enable;
        end
    end

    // lookup byte narrows the match vector
    always_comb begin
        n_match = r_match;
        for (int e = 0; e < NK; e++) begin
            if (r_s1_pos >= kemt_pkg::WPOS_MAX ||
                int'(r_s1_pos) >= int'(r_len[e]) ||
                ram_q[e] != r_s1_byte) begin
                n_match[e] = 1'b0;
            end
        end
    end

    // end of word: exact length match on active entries, lowest wins
    always_comb begin
        hit_idx = '0;
        for (int e = 0; e < NK; e++) begin
            hit[e] = r_act[e] && r_match[e] &&
                     int'(r_len[e]) <= kemt_pkg::MAX_KEYWORD_LEN &&
                     int'(r_len[e]) == int'(r_s1_pos);
        end
        for (int e = NK - 1; e >= 0; e--) begin
            if (hit[e]) begin
                hit_idx = kemt_pkg::IDX_W'(e);
            end
        end
    end
    assign any_hit = |hit;

    // header and match-vector update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act   <= '0;
            r_match <= '1;
            for (int e = 0; e < NK; e++) begin
                r_len[e] <= '0;
            end
        end else if (s1_go) begin
            case (r_s1_op)
                kemt_pkg::OP_HEADER: begin
                    if (r_s1_inrange) begin
                        r_len[r_s1_idx] <= r_s1_len;
                        r_act[r_s1_idx] <= r_s1_en;
                    end
                end
                kemt_pkg::OP_LOOKUP: begin
                    r_match <= n_match;
                end
                kemt_pkg::OP_END: begin
                    r_match <= '1;
                end
                default: begin
                end
            endcase
        end
    end

    // tags carry no reset
    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_op == kemt_pkg::OP_HEADER && r_s1_inrange) begin
            r_tag[r_s1_idx] <= r_s1_tag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_op == kemt_pkg::OP_END) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_op == kemt_pkg::OP_END) begin
            r_out_found <= any_hit;
            r_out_tag   <= any_hit ? r_tag[hit_idx] : '0;
            r_out_entry <= any_hit ? kemt_pkg::ENTRY_W'(hit_idx) : '0;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.match_tag   = r_out_tag;
    assign o_out.match_entry = r_out_entry;

    // checks
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_op == kemt_pkg::OP_END |=> r_out_valid)
        else $error("end item retired without a result");

    a_end_clears_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && r_s1_op == kemt_pkg::OP_END |=> r_match == '1)
        else $error("match vector not cleared after end of word");

    a_pos_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= kemt_pkg::WPOS_SAT)
        else $error("word position beyond saturation");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_tag == '0 && r_out_entry == '0)
        else $error("miss result carries nonzero tag or entry");

endmodule

`default_nettype wire
